// ----- src/chip8_f_group_execute_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the CHIP-8 Fxxx execute unit
// Concurrent checks; compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef CHIP8_F_GROUP_EXECUTE_UNIT_MACROS_SVH
`define CHIP8_F_GROUP_EXECUTE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// ante implies cons in the same cycle
`define C8F_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// ante implies cons in the next cycle
`define C8F_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`else

`define C8F_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define C8F_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/c8f_pkg.sv -----
// ---------------------------------------------------------------------------
// c8f_pkg
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package c8f_pkg;

  localparam int MEM_DEPTH   = 4096;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int NUM_KEYS    = 16;
  localparam int GLYPH_BYTES = 5;
  localparam int NUM_REGS    = 16;
  localparam int RIDX_W      = $clog2(NUM_REGS);

  localparam logic [11:0] FONT_BASE_RST = 12'd80;
  localparam logic [15:0] X_FIELD_MASK  = 16'h0F00;

  localparam int BCD_HUNDRED = 100;
  localparam int BCD_TEN     = 10;

  // action codes
  localparam logic [1:0] ACT_EXEC   = 2'd0;
  localparam logic [1:0] ACT_HWRITE = 2'd1;
  localparam logic [1:0] ACT_HREAD  = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REPEAT = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  // Fxnn low byte codes
  localparam logic [7:0] LB_RD_DELAY  = 8'h07;
  localparam logic [7:0] LB_KEY       = 8'h0A;
  localparam logic [7:0] LB_SET_DELAY = 8'h15;
  localparam logic [7:0] LB_SET_SOUND = 8'h18;
  localparam logic [7:0] LB_ADD_I     = 8'h1E;
  localparam logic [7:0] LB_FONT      = 8'h29;
  localparam logic [7:0] LB_BCD       = 8'h33;
  localparam logic [7:0] LB_STORE     = 8'h55;
  localparam logic [7:0] LB_LOAD      = 8'h65;
  localparam logic [3:0] OPC_GROUP_F  = 4'hF;

  typedef enum logic [3:0] {
    OP_RD_DELAY,
    OP_KEY,
    OP_SET_DELAY,
    OP_SET_SOUND,
    OP_ADD_I,
    OP_FONT,
    OP_BCD,
    OP_STORE,
    OP_LOAD,
    OP_HWRITE,
    OP_HREAD,
    OP_BAD
  } op_t;

  typedef struct packed {
    logic capture;   // latch the input item
    logic exec;      // single-step operation or host write
    logic mem_rd;    // host read of memory
    logic bcd_wr;    // write one BCD digit
    logic st_wr;     // write V[cnt] to memory
    logic ld_rd;     // read memory for V[cnt]
    logic cnt_inc;
    logic out_load;  // load the result register
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic cnt_last;  // cnt == x
    logic bcd_last;  // last BCD digit
  } sts_t;

endpackage

// ----- src/c8f_ctrl.sv -----
// ---------------------------------------------------------------------------
// c8f_ctrl
// Sequencer: decode dispatch, memory sweeps and result handoff.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module c8f_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  c8f_pkg::sts_t sts,
  output c8f_pkg::cmd_t cmd
);
  import c8f_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_BCD,
    S_STORE,
    S_LOAD,
    S_LDRAIN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_BCD:   state_nxt = S_BCD;
          OP_STORE: state_nxt = S_STORE;
          OP_LOAD:  state_nxt = S_LOAD;
          OP_HREAD: begin
            cmd.mem_rd = 1'b1;
            state_nxt  = S_FINISH;
          end
          default: begin
            cmd.exec  = 1'b1;
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_BCD: begin
        cmd.bcd_wr = 1'b1;
        if (sts.bcd_last) state_nxt = S_FINISH;
        else cmd.cnt_inc = 1'b1;
      end
      S_STORE: begin
        cmd.st_wr = 1'b1;
        if (sts.cnt_last) state_nxt = S_FINISH;
        else cmd.cnt_inc = 1'b1;
      end
      S_LOAD: begin
        cmd.ld_rd = 1'b1;
        if (sts.cnt_last) state_nxt = S_LDRAIN;
        else cmd.cnt_inc = 1'b1;
      end
      // last loaded byte lands in the register file here
      S_LDRAIN: state_nxt = S_FINISH;
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/c8f_datapath.sv -----
// ---------------------------------------------------------------------------
// c8f_datapath
// Register file, index, timers, byte memory and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module c8f_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [11:0]   cfg_wr_data,
  input  logic [1:0]    action,
  input  logic [15:0]   opcode_word,
  input  logic [15:0]   key_mask,
  input  logic [11:0]   host_address,
  input  logic [7:0]    host_data,
  input  c8f_pkg::cmd_t cmd,
  output c8f_pkg::sts_t sts,
  output logic [1:0]    status,
  output logic [7:0]    reg_x_value,
  output logic [15:0]   index_value,
  output logic [7:0]    delay_value,
  output logic [7:0]    sound_value,
  output logic [7:0]    read_data
);
  import c8f_pkg::*;

  // digits of an 8-bit value, compare based
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [1:0] h;
    logic [7:0] rem;
    logic [3:0] t;
    logic [7:0] o;
    h = 2'd0;
    if (v >= 8'(2 * BCD_HUNDRED)) h = 2'd2;
    else if (v >= 8'(BCD_HUNDRED)) h = 2'd1;
    rem = v - ((h == 2'd2) ? 8'(2 * BCD_HUNDRED) : (h == 2'd1) ? 8'(BCD_HUNDRED) : 8'd0);
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= 8'(k * BCD_TEN)) t = 4'(k);
    end
    o = rem - ({4'd0, t} << 3) - ({4'd0, t} << 1);
    return {2'b00, h, t, o[3:0]};
  endfunction

  // latched item
  logic [1:0]  action_r;
  logic [15:0] op_r;
  logic [15:0] keys_r;
  logic [11:0] haddr_r;
  logic [7:0]  hdata_r;

  // architectural state
  logic [7:0]  v_r [NUM_REGS];
  logic [15:0] idx_r;
  logic [7:0]  dly_r;
  logic [7:0]  snd_r;
  logic [11:0] font_r;
  logic [7:0]  mem [MEM_DEPTH];
  logic [7:0]  mem_q_r;

  logic [RIDX_W-1:0] cnt_r;
  logic [RIDX_W-1:0] wcnt_r;
  logic              ld_pend_r;

  logic [RIDX_W-1:0] x;
  logic [RIDX_W-1:0] rd_idx;
  logic [7:0]        vsel;
  op_t               op;
  logic              key_any;
  logic [RIDX_W-1:0] key_idx;
  logic [11:0]       digits;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic              mem_we;
  logic              mem_re;
  logic [1:0]        status_c;

  assign x      = RIDX_W'((op_r & X_FIELD_MASK) >> 8);
  assign rd_idx = cmd.st_wr ? cnt_r : x;
  assign vsel   = v_r[rd_idx];
  assign digits = bcd_digits(vsel);

  always_comb begin
    op = OP_BAD;
    case (action_r)
      ACT_HWRITE: op = OP_HWRITE;
      ACT_HREAD:  op = OP_HREAD;
      ACT_EXEC: begin
        if (op_r[15:12] == OPC_GROUP_F) begin
          case (op_r[7:0])
            LB_RD_DELAY:  op = OP_RD_DELAY;
            LB_KEY:       op = OP_KEY;
            LB_SET_DELAY: op = OP_SET_DELAY;
            LB_SET_SOUND: op = OP_SET_SOUND;
            LB_ADD_I:     op = OP_ADD_I;
            LB_FONT:      op = OP_FONT;
            LB_BCD:       op = OP_BCD;
            LB_STORE:     op = OP_STORE;
            LB_LOAD:      op = OP_LOAD;
            default:      op = OP_BAD;
          endcase
        end
      end
      default: op = OP_BAD;
    endcase
  end

  // lowest pressed key
  always_comb begin
    key_idx = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (keys_r[i]) key_idx = RIDX_W'(i);
    end
  end
  assign key_any = |keys_r;

  assign sts.op       = op;
  assign sts.cnt_last = (cnt_r == x);
  assign sts.bcd_last = (cnt_r == RIDX_W'(2));

  // one memory port: host address or I + cnt, wrapped
  always_comb begin
    if (op == OP_HWRITE || op == OP_HREAD) mem_addr = ADDR_W'(haddr_r);
    else mem_addr = ADDR_W'(idx_r + 16'(cnt_r));
    mem_we = (cmd.exec && op == OP_HWRITE) || cmd.bcd_wr || cmd.st_wr;
    mem_re = cmd.mem_rd || cmd.ld_rd;
    if (cmd.bcd_wr) begin
      case (cnt_r)
        RIDX_W'(0): mem_wdata = {6'd0, digits[9:8]};
        RIDX_W'(1): mem_wdata = {4'd0, digits[7:4]};
        default:    mem_wdata = {4'd0, digits[3:0]};
      endcase
    end else if (cmd.st_wr) begin
      mem_wdata = vsel;
    end else begin
      mem_wdata = hdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) mem_q_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= action;
      op_r     <= opcode_word;
      keys_r   <= key_mask;
      haddr_r  <= host_address;
      hdata_r  <= host_data;
    end
    if (cmd.ld_rd) wcnt_r <= cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) v_r[i] <= 8'd0;
      idx_r     <= 16'd0;
      dly_r     <= 8'd0;
      snd_r     <= 8'd0;
      font_r    <= FONT_BASE_RST;
      cnt_r     <= '0;
      ld_pend_r <= 1'b0;
    end else begin
      if (cfg_wr_en) font_r <= cfg_wr_data;
      if (cmd.capture) cnt_r <= '0;
      else if (cmd.cnt_inc) cnt_r <= cnt_r + RIDX_W'(1);
      ld_pend_r <= cmd.ld_rd;
      // loaded byte is written in the cycle after its read
      if (ld_pend_r) v_r[wcnt_r] <= mem_q_r;
      if (cmd.exec) begin
        case (op)
          OP_RD_DELAY:  v_r[x] <= dly_r;
          OP_KEY:       if (key_any) v_r[x] <= {{(8 - RIDX_W){1'b0}}, key_idx};
          OP_SET_DELAY: dly_r <= vsel;
          OP_SET_SOUND: snd_r <= vsel;
          OP_ADD_I:     idx_r <= idx_r + {8'd0, vsel};
          OP_FONT:      idx_r <= {4'd0, font_r} + {8'd0, vsel} * 16'(GLYPH_BYTES);
          default:      ;
        endcase
      end
    end
  end

  always_comb begin
    status_c = ST_DONE;
    if (op == OP_BAD) status_c = ST_BAD;
    else if (op == OP_KEY && !key_any) status_c = ST_REPEAT;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= status_c;
      reg_x_value <= vsel;
      index_value <= idx_r;
      delay_value <= dly_r;
      sound_value <= snd_r;
      read_data   <= (op == OP_HREAD) ? mem_q_r : 8'd0;
    end
  end

endmodule

// ----- src/chip8_f_group_execute_unit.sv -----
// ---------------------------------------------------------------------------
// chip8_f_group_execute_unit
// Single-step operations and host accesses run decode then finish; FX33, FX55
// and FX65 sweep memory through its one port, FX65 with a drain step.
// One item at a time: the next item is taken the cycle after its result is
// loaded, even while that result waits.
// Synchronous active-low reset clears V0..VF, I, timers and the sequencer;
// font_base resets to 80. Byte memory is not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chip8_f_group_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,   // font_base
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,      // opcode_word, key_mask, host_address, host_data
  input  logic [1:0]  in_tuser,      // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,     // reg_x_value, index_value, delay_value,
                                     // sound_value, read_data
  output logic [1:0]  out_tuser      // status
);
  import c8f_pkg::*;

  `include "chip8_f_group_execute_unit_macros.svh"

  cmd_t        cmd;
  sts_t        sts;
  logic [7:0]  reg_x_value;
  logic [15:0] index_value;
  logic [7:0]  delay_value;
  logic [7:0]  sound_value;
  logic [7:0]  read_data;

  c8f_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  c8f_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .action       (in_tuser),
    .opcode_word  (in_tdata[15:0]),
    .key_mask     (in_tdata[31:16]),
    .host_address (in_tdata[43:32]),
    .host_data    (in_tdata[51:44]),
    .cmd          (cmd),
    .sts          (sts),
    .status       (out_tuser),
    .reg_x_value  (reg_x_value),
    .index_value  (index_value),
    .delay_value  (delay_value),
    .sound_value  (sound_value),
    .read_data    (read_data)
  );

  assign out_tdata = {read_data, sound_value, delay_value, index_value, reg_x_value};

  // one item in flight
  `C8F_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // a waiting result is never overwritten
  `C8F_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.out_load, !out_tvalid || out_tready)
  // datapath commands other than cnt_inc are exclusive
  `C8F_ASSERT_SAME(a_cmd_excl, clk, rst_n, 1'b1,
    $onehot0({cmd.capture, cmd.exec, cmd.mem_rd, cmd.bcd_wr, cmd.st_wr, cmd.ld_rd,
              cmd.out_load}))

endmodule
